// ===== rtl/spp_pkg.sv =====
// Shared types and constants of the strip packet parser.
// Used by spp_parse, strip_packet_parser_core and the testbench; depends on nothing.
`default_nettype none

package spp_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned POS_W  = 18;
	localparam int unsigned SEC_W  = 10;
	localparam int unsigned VTX_W  = 8;

	// Word kinds
	localparam logic [2:0] KIND_FRAME    = 3'd0;
	localparam logic [2:0] KIND_POSITION = 3'd1;
	localparam logic [2:0] KIND_NORMAL   = 3'd2;
	localparam logic [2:0] KIND_COLOUR   = 3'd3;
	localparam logic [2:0] KIND_TEXCOORD = 3'd4;
	localparam logic [2:0] KIND_IGNORED  = 3'd5;
	localparam logic [2:0] KIND_FAULTY   = 3'd6;

	// Error codes
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_STRIP_HDR = 4'd1;
	localparam logic [3:0] ERR_POS_HDR   = 4'd2;
	localparam logic [3:0] ERR_POS_CNT   = 4'd3;
	localparam logic [3:0] ERR_NRM_HDR   = 4'd4;
	localparam logic [3:0] ERR_NRM_CNT   = 4'd5;
	localparam logic [3:0] ERR_COL_HDR   = 4'd6;
	localparam logic [3:0] ERR_COL_CNT   = 4'd7;
	localparam logic [3:0] ERR_TEX_HDR   = 4'd8;
	localparam logic [3:0] ERR_TEX_CNT   = 4'd9;

	localparam logic [WORD_W-1:0] STRIP_HDR  = 32'h6401_8000;
	localparam logic [WORD_W-1:0] HDR_MASK   = 32'hFF00_FFFF;
	localparam logic [SEC_W-1:0]  TRAILER_LEN = 10'd3;

	localparam logic [WORD_W-1:0] SEC_EXPECT [4] = '{
		32'h6800_8001, 32'h6900_8002, 32'h6E00_C003, 32'h6400_8004
	};
	localparam logic [2:0] SEC_KIND [4] = '{
		KIND_POSITION, KIND_NORMAL, KIND_COLOUR, KIND_TEXCOORD
	};
	localparam logic [3:0] SEC_HDR_ERR [4] = '{
		ERR_POS_HDR, ERR_NRM_HDR, ERR_COL_HDR, ERR_TEX_HDR
	};
	localparam logic [3:0] SEC_CNT_ERR [4] = '{
		ERR_POS_CNT, ERR_NRM_CNT, ERR_COL_CNT, ERR_TEX_CNT
	};

	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [2:0]        word_kind;
		logic [SEC_W-1:0]  element_index;
		logic [VTX_W-1:0]  strip_vertices;
		logic              strip_end;
		logic              block_end;
		logic [3:0]        error_code;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/spp_parse.sv =====
// Parser state and word classification for the strip packet parser.
// Depends on spp_pkg; the state advances on every fired item.
`default_nettype none

module spp_parse (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        fire,
	input  wire logic [spp_pkg::WORD_W-1:0]  word,
	input  wire logic                        block_start,
	output spp_pkg::result_t                 result
);

	typedef enum logic [14:0] {
		PH_IDLE    = 15'b000_0000_0000_0001,
		PH_SKIP    = 15'b000_0000_0000_0010,
		PH_TAG     = 15'b000_0000_0000_0100,
		PH_SHDR    = 15'b000_0000_0000_1000,
		PH_COUNT   = 15'b000_0000_0001_0000,
		PH_SPARE   = 15'b000_0000_0010_0000,
		PH_HDR0    = 15'b000_0000_0100_0000,
		PH_DAT0    = 15'b000_0000_1000_0000,
		PH_HDR1    = 15'b000_0001_0000_0000,
		PH_DAT1    = 15'b000_0010_0000_0000,
		PH_HDR2    = 15'b000_0100_0000_0000,
		PH_DAT2    = 15'b000_1000_0000_0000,
		PH_HDR3    = 15'b001_0000_0000_0000,
		PH_DAT3    = 15'b010_0000_0000_0000,
		PH_TRAILER = 15'b100_0000_0000_0000
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic [spp_pkg::POS_W-1:0]    pos_q, pos_d, pos_inc;
	logic [spp_pkg::POS_W-1:0]    limit_q, limit_d;
	logic [spp_pkg::SEC_W-1:0]    left_q, left_d, left_dec;
	logic [spp_pkg::SEC_W-1:0]    offset_q, offset_d;
	logic [spp_pkg::VTX_W-1:0]    vcount_q, vcount_d;
	logic                         wide_q, wide_d;
	logic [1:0]                   sec;
	logic [spp_pkg::SEC_W-1:0]    n_ext, n_x2, n_x3, sec_len;
	phase_t                       next_hdr;

	always_comb begin
		unique case (phase_q)
			PH_HDR1, PH_DAT1: sec = 2'd1;
			PH_HDR2, PH_DAT2: sec = 2'd2;
			PH_HDR3, PH_DAT3: sec = 2'd3;
			default:          sec = 2'd0;
		endcase
	end

	always_comb begin
		n_ext = {2'b00, vcount_q};
		n_x2  = {1'b0, vcount_q, 1'b0};
		n_x3  = n_ext + n_x2;
		unique case (sec)
			2'd0: sec_len = n_x3;
			2'd1: sec_len = (n_x3 + 10'd1) >> 1;
			2'd2: sec_len = n_ext;
			2'd3: sec_len = n_x2;
		endcase
		unique case (sec)
			2'd0: next_hdr = PH_HDR1;
			2'd1: next_hdr = PH_HDR2;
			default: next_hdr = PH_HDR3;
		endcase
	end

	assign pos_inc  = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
	assign left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		limit_d  = limit_q;
		left_d   = left_q;
		offset_d = offset_q;
		vcount_d = vcount_q;
		wide_d   = wide_q;
		result.data          = word;
		result.word_kind     = spp_pkg::KIND_FRAME;
		result.element_index = '0;
		result.strip_end     = 1'b0;
		result.block_end     = 1'b0;
		result.error_code    = spp_pkg::ERR_NONE;

		if (block_start) begin
			limit_d  = {word[15:0], 2'b00};
			pos_d    = spp_pkg::POS_W'(1);
			left_d   = '0;
			offset_d = '0;
			vcount_d = '0;
			wide_d   = 1'b0;
			phase_d  = PH_SKIP;
		end else if (phase_q == PH_IDLE) begin
			result.word_kind = spp_pkg::KIND_IGNORED;
		end else begin
			pos_d = pos_inc;
			unique case (phase_q)
				PH_SKIP: begin
					if (pos_inc >= limit_q) begin
						result.block_end = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_TAG;
					end
				end
				PH_TAG: begin
					vcount_d = '0;
					wide_d   = 1'b0;
					phase_d  = PH_SHDR;
				end
				PH_SPARE: phase_d = PH_HDR0;
				PH_SHDR: begin
					if (word == spp_pkg::STRIP_HDR) begin
						phase_d = PH_COUNT;
					end else begin
						result.word_kind  = spp_pkg::KIND_FAULTY;
						result.error_code = spp_pkg::ERR_STRIP_HDR;
						phase_d = PH_IDLE;
					end
				end
				PH_COUNT: begin
					wide_d   = (word[31:8] != '0);
					vcount_d = (word[31:8] != '0) ? '1 : word[7:0];
					phase_d  = PH_SPARE;
				end
				PH_TRAILER: begin
					left_d = left_dec;
					if (left_dec == '0) begin
						result.strip_end = 1'b1;
						if (pos_inc >= limit_q) begin
							result.block_end = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_TAG;
						end
					end
				end
				PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
					if ((word & spp_pkg::HDR_MASK) != spp_pkg::SEC_EXPECT[sec]) begin
						result.word_kind  = spp_pkg::KIND_FAULTY;
						result.error_code = spp_pkg::SEC_HDR_ERR[sec];
						phase_d = PH_IDLE;
					end else if (wide_q || word[23:16] != vcount_q) begin
						result.word_kind  = spp_pkg::KIND_FAULTY;
						result.error_code = spp_pkg::SEC_CNT_ERR[sec];
						phase_d = PH_IDLE;
					end else if (sec_len == '0) begin
						// empty section: go straight to the next header or trailer
						offset_d = '0;
						if (sec == 2'd3) begin
							phase_d = PH_TRAILER;
							left_d  = spp_pkg::TRAILER_LEN;
						end else begin
							phase_d = next_hdr;
							left_d  = '0;
						end
					end else begin
						left_d   = sec_len;
						offset_d = '0;
						phase_d  = phase_t'({phase_q[13:0], 1'b0});
					end
				end
				PH_DAT0, PH_DAT1, PH_DAT2, PH_DAT3: begin
					result.word_kind     = spp_pkg::SEC_KIND[sec];
					result.element_index = offset_q;
					offset_d = offset_q + 1'b1;
					left_d   = left_dec;
					if (left_dec == '0) begin
						offset_d = '0;
						if (sec == 2'd3) begin
							phase_d = PH_TRAILER;
							left_d  = spp_pkg::TRAILER_LEN;
						end else begin
							phase_d = next_hdr;
						end
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
		result.strip_vertices = vcount_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			limit_q  <= '0;
			left_q   <= '0;
			offset_q <= '0;
			vcount_q <= '0;
			wide_q   <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			limit_q  <= limit_d;
			left_q   <= left_d;
			offset_q <= offset_d;
			vcount_q <= vcount_d;
			wide_q   <= wide_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/strip_packet_parser_core.sv =====
// Top level of the strip packet parser: input register, parser, result register.
// Depends on spp_pkg and spp_parse.
//
// channel | direction | handshake             | payload
// in      | to core   | in_valid / in_stall   | word, block_start
// out     | from core | out_valid / out_stall | data, word_kind, element_index,
//         |           |                       | strip_vertices, strip_end,
//         |           |                       | block_end, error_code
//
// One item per cycle while out_stall is low; a word passes the input register,
// the parser and the result register; one parser state update sets the rate.
// Reset clears the parser to idle and empties both registers.
// A stalled result holds; the input register keeps one item meanwhile,
// after which in_stall rises.
`default_nettype none

module strip_packet_parser_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [spp_pkg::WORD_W-1:0]  word,
	input  wire logic                        block_start,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [spp_pkg::WORD_W-1:0]       data,
	output logic [2:0]                       word_kind,
	output logic [spp_pkg::SEC_W-1:0]        element_index,
	output logic [spp_pkg::VTX_W-1:0]        strip_vertices,
	output logic                             strip_end,
	output logic                             block_end,
	output logic [3:0]                       error_code
);

	logic                         valid_s1;
	logic [spp_pkg::WORD_W-1:0]   word_s1;
	logic                         start_s1;
	logic                         out_valid_q;
	spp_pkg::result_t             result_q;
	spp_pkg::result_t             result;
	logic                         out_free;
	logic                         fire;
	logic                         in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			out_valid_q <= fire || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1  <= word;
			start_s1 <= block_start;
		end
		if (fire) begin
			result_q <= result;
		end
	end

	spp_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.word        (word_s1),
		.block_start (start_s1),
		.result      (result)
	);

	assign out_valid      = out_valid_q;
	assign data           = result_q.data;
	assign word_kind      = result_q.word_kind;
	assign element_index  = result_q.element_index;
	assign strip_vertices = result_q.strip_vertices;
	assign strip_end      = result_q.strip_end;
	assign block_end      = result_q.block_end;
	assign error_code     = result_q.error_code;

endmodule

`default_nettype wire

// ===== verif/strip_packet_parser_core_tb.sv =====
// Self-checking testbench of strip_packet_parser_core: drives part blocks, predicts each
// classified word and checks it against the block. Depends on spp_pkg and the RTL only.
`timescale 1ns / 100ps

module strip_packet_parser_core_tb;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int MAX_REPORTS = 10;
	localparam logic [spp_pkg::POS_W-1:0] POS_SAT = '1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SKIP, ST_TAG, ST_SHDR, ST_COUNT, ST_SPARE, ST_HDR, ST_DATA, ST_TRAILER
	} parse_st_t;

	typedef enum int {
		FLAW_NONE, FLAW_STRIP_HDR, FLAW_WIDE_CNT, FLAW_SEC_HDR, FLAW_SEC_CNT, FLAW_CUT
	} flaw_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [spp_pkg::WORD_W-1:0]   word;
	logic                         block_start;
	logic                         out_valid;
	logic                         out_stall;
	logic [spp_pkg::WORD_W-1:0]   data;
	logic [2:0]                   word_kind;
	logic [spp_pkg::SEC_W-1:0]    element_index;
	logic [spp_pkg::VTX_W-1:0]    strip_vertices;
	logic                         strip_end;
	logic                         block_end;
	logic [3:0]                   error_code;

	// parser state as predicted
	parse_st_t                    st = ST_IDLE;
	logic [spp_pkg::POS_W-1:0]    blk_pos = '0;
	logic [spp_pkg::POS_W-1:0]    blk_lim = '0;
	logic [spp_pkg::SEC_W-1:0]    sec_left = '0;
	logic [spp_pkg::SEC_W-1:0]    sec_off = '0;
	logic [spp_pkg::VTX_W-1:0]    vtx_n = '0;
	logic                         vtx_wide = 1'b0;
	int                           sec_id = 0;

	spp_pkg::result_t             pending_tags [$];
	spp_pkg::result_t             got_res;
	spp_pkg::result_t             want_res;
	int                           useful_words = 0;
	int                           mismatch_cnt = 0;
	int                           cycle_cnt = 0;
	int                           idle_pct = 0;
	int                           stall_pct = 0;
	int                           hold_left = 0;

	strip_packet_parser_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.word           (word),
		.block_start    (block_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data           (data),
		.word_kind      (word_kind),
		.element_index  (element_index),
		.strip_vertices (strip_vertices),
		.strip_end      (strip_end),
		.block_end      (block_end),
		.error_code     (error_code)
	);

	always #6 clk = ~clk;

	function automatic int unsigned section_words(input int sec, input int unsigned n);
		case (sec)
			0: return 3 * n;
			1: return (3 * n + 1) / 2;
			2: return n;
			default: return 2 * n;
		endcase
	endfunction

	function void advance_section();
		sec_off = '0;
		if (sec_id == 3) begin
			st = ST_TRAILER;
			sec_left = spp_pkg::TRAILER_LEN;
		end else begin
			sec_id = sec_id + 1;
			st = ST_HDR;
			sec_left = '0;
		end
	endfunction

	function spp_pkg::result_t classify_word(input logic [spp_pkg::WORD_W-1:0] w,
			input logic start);
		spp_pkg::result_t r;
		int unsigned len;
		r = '0;
		r.data = w;
		r.word_kind = spp_pkg::KIND_FRAME;
		r.error_code = spp_pkg::ERR_NONE;
		if (start) begin
			blk_lim = {w[15:0], 2'b00};
			blk_pos = spp_pkg::POS_W'(1);
			sec_left = '0;
			sec_off = '0;
			vtx_n = '0;
			vtx_wide = 1'b0;
			st = ST_SKIP;
		end else if (st == ST_IDLE) begin
			r.word_kind = spp_pkg::KIND_IGNORED;
		end else begin
			if (blk_pos != POS_SAT)
				blk_pos = blk_pos + 1'b1;
			case (st)
				ST_SKIP: begin
					if (blk_pos >= blk_lim) begin
						r.block_end = 1'b1;
						st = ST_IDLE;
					end else begin
						st = ST_TAG;
					end
				end
				ST_TAG: begin
					vtx_n = '0;
					vtx_wide = 1'b0;
					st = ST_SHDR;
				end
				ST_SPARE: begin
					sec_id = 0;
					st = ST_HDR;
				end
				ST_SHDR: begin
					if (w == spp_pkg::STRIP_HDR) begin
						st = ST_COUNT;
					end else begin
						r.word_kind = spp_pkg::KIND_FAULTY;
						r.error_code = spp_pkg::ERR_STRIP_HDR;
						st = ST_IDLE;
					end
				end
				ST_COUNT: begin
					vtx_wide = (w > 32'd255);
					vtx_n = vtx_wide ? 8'hFF : w[7:0];
					st = ST_SPARE;
				end
				ST_TRAILER: begin
					if (sec_left != 0)
						sec_left = sec_left - 1'b1;
					if (sec_left == 0) begin
						r.strip_end = 1'b1;
						if (blk_pos >= blk_lim) begin
							r.block_end = 1'b1;
							st = ST_IDLE;
						end else begin
							st = ST_TAG;
						end
					end
				end
				ST_HDR: begin
					if ((w & spp_pkg::HDR_MASK) != spp_pkg::SEC_EXPECT[sec_id]) begin
						r.word_kind = spp_pkg::KIND_FAULTY;
						r.error_code = spp_pkg::SEC_HDR_ERR[sec_id];
						st = ST_IDLE;
					end else if (vtx_wide || w[23:16] != vtx_n) begin
						r.word_kind = spp_pkg::KIND_FAULTY;
						r.error_code = spp_pkg::SEC_CNT_ERR[sec_id];
						st = ST_IDLE;
					end else begin
						len = section_words(sec_id, vtx_n);
						if (len == 0) begin
							advance_section();
						end else begin
							sec_left = spp_pkg::SEC_W'(len);
							sec_off = '0;
							st = ST_DATA;
						end
					end
				end
				ST_DATA: begin
					r.word_kind = spp_pkg::SEC_KIND[sec_id];
					r.element_index = sec_off;
					sec_off = sec_off + 1'b1;
					if (sec_left != 0)
						sec_left = sec_left - 1'b1;
					if (sec_left == 0)
						advance_section();
				end
				default: st = ST_IDLE;
			endcase
		end
		r.strip_vertices = vtx_n;
		return r;
	endfunction

	task automatic send_word(input logic [spp_pkg::WORD_W-1:0] w, input logic start);
		spp_pkg::result_t r;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		word <= w;
		block_start <= start;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = classify_word(w, start);
		pending_tags.push_back(r);
		if (r.word_kind != spp_pkg::KIND_IGNORED)
			useful_words++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_tags.size() != 0)
			@(posedge clk);
	endtask

	// n-vertex strip; a flaw corrupts or truncates it, section flaws in section fsec.
	task automatic send_strip(input int unsigned n, input flaw_t flaw, input int fsec);
		logic [spp_pkg::WORD_W-1:0] cnt_w;
		logic [spp_pkg::WORD_W-1:0] hw;
		int unsigned len;
		int s;
		int b;
		send_word($urandom, 1'b0);
		if (flaw == FLAW_STRIP_HDR) begin
			send_word(spp_pkg::STRIP_HDR ^ (32'h1 << $urandom_range(31)), 1'b0);
			repeat ($urandom_range(3)) send_word($urandom, 1'b0);
			return;
		end
		send_word(spp_pkg::STRIP_HDR, 1'b0);
		cnt_w = n;
		if (flaw == FLAW_WIDE_CNT) begin
			cnt_w = $urandom | (32'h100 << $urandom_range(23));
			n = 255;
		end
		send_word(cnt_w, 1'b0);
		send_word($urandom, 1'b0);
		for (s = 0; s < 4; s++) begin
			hw = spp_pkg::SEC_EXPECT[s] | {8'h00, 8'(n), 16'h0000};
			if (s == fsec && flaw == FLAW_SEC_HDR) begin
				// flip one bit outside the count field
				b = $urandom_range(23);
				if (b >= 16)
					b = b + 8;
				hw = hw ^ (32'h1 << b);
			end
			if (s == fsec && flaw == FLAW_SEC_CNT)
				hw[23:16] = hw[23:16] ^ 8'($urandom_range(1, 255));
			send_word(hw, 1'b0);
			if (flaw == FLAW_WIDE_CNT
					|| (s == fsec && (flaw == FLAW_SEC_HDR || flaw == FLAW_SEC_CNT))) begin
				repeat ($urandom_range(3)) send_word($urandom, 1'b0);
				return;
			end
			len = section_words(s, n);
			if (flaw == FLAW_CUT && s == fsec)
				len = len / 2;
			repeat (len) send_word($urandom, 1'b0);
			if (flaw == FLAW_CUT && s == fsec)
				return;
		end
		repeat (3) send_word($urandom, 1'b0);
	endtask

	task automatic send_random_block();
		int unsigned nv [3];
		int unsigned lead;
		int nstr;
		int i;
		logic [15:0] lim;
		flaw_t fl;
		nstr = $urandom_range(1, 3);
		for (i = 0; i < nstr; i++)
			nv[i] = ($urandom_range(19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
		// words up to the end of the next-to-last strip
		lead = 2;
		for (i = 0; i < nstr - 1; i++)
			lead += 11 + 6 * nv[i] + (3 * nv[i] + 1) / 2;
		case ($urandom_range(9))
			0: lim = 16'($urandom_range(0, 5));
			1: lim = 16'((lead + 4) / 4 + $urandom_range(1, 8));
			default: lim = 16'((lead + 4) / 4);
		endcase
		send_word({16'($urandom), lim}, 1'b1);
		send_word($urandom, 1'b0);
		for (i = 0; i < nstr; i++) begin
			fl = ($urandom_range(5) == 0) ? flaw_t'($urandom_range(1, 5)) : FLAW_NONE;
			send_strip(nv[i], fl, $urandom_range(3));
		end
	endtask

	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		send_word(32'h0000_0000, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		// zero limit: block ends on the skipped word
		send_word(32'hFFFF_0000, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b0);
		// limit of four words: the strip runs past it
		send_word(32'h0000_0001, 1'b1);
		send_word(32'h0000_0000, 1'b0);
		send_strip(1, FLAW_NONE, 0);
		drain_results();
	endtask

	task automatic test_faults();
		int f;
		int s;
		idle_pct = 13;
		stall_pct = 13;
		for (f = FLAW_STRIP_HDR; f <= FLAW_CUT; f++) begin
			for (s = 0; s < 4; s++) begin
				send_word({16'($urandom), 16'd4}, 1'b1);
				send_word($urandom, 1'b0);
				send_strip($urandom_range(0, 3), flaw_t'(f), s);
			end
		end
		drain_results();
	endtask

	task automatic test_random_blocks(input int target, input int idle, input int stall);
		int base;
		idle_pct = idle;
		stall_pct = stall;
		base = useful_words;
		while (useful_words - base < target) begin
			if ($urandom_range(99) < 8)
				repeat ($urandom_range(1, 4)) send_word($urandom, ($urandom_range(3) == 0));
			else
				send_random_block();
		end
		drain_results();
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		send_word({16'($urandom), 16'd1}, 1'b1);
		// hold the output off while the sender keeps offering words
		hold_left = 300;
		send_word($urandom, 1'b0);
		send_strip(6, FLAW_NONE, 0);
		drain_results();
		send_word({16'($urandom), 16'd0}, 1'b1);
		send_word($urandom, 1'b0);
		drain_results();
	endtask

	task automatic test_large_strip();
		idle_pct = 13;
		stall_pct = 13;
		// full vertex count; the position header carries a wrong count
		send_word({16'($urandom), 16'd1}, 1'b1);
		send_word($urandom, 1'b0);
		send_strip(255, FLAW_SEC_CNT, 0);
		send_word({16'($urandom), 16'd1}, 1'b1);
		send_word($urandom, 1'b0);
		send_strip(7, FLAW_WIDE_CNT, 0);
		drain_results();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_res.data = data;
			got_res.word_kind = word_kind;
			got_res.element_index = element_index;
			got_res.strip_vertices = strip_vertices;
			got_res.strip_end = strip_end;
			got_res.block_end = block_end;
			got_res.error_code = error_code;
			if (pending_tags.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display({"unexpected result: data=%h kind=%0d idx=%0d vtx=%0d ",
						"se=%b be=%b err=%0d"},
						got_res.data, got_res.word_kind, got_res.element_index,
						got_res.strip_vertices, got_res.strip_end, got_res.block_end,
						got_res.error_code);
			end else begin
				want_res = pending_tags.pop_front();
				if (got_res.data !== want_res.data
						|| got_res.word_kind !== want_res.word_kind
						|| got_res.element_index !== want_res.element_index
						|| got_res.strip_vertices !== want_res.strip_vertices
						|| got_res.strip_end !== want_res.strip_end
						|| got_res.block_end !== want_res.block_end
						|| got_res.error_code !== want_res.error_code) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display({"mismatch: expected data=%h kind=%0d idx=%0d vtx=%0d ",
							"se=%b be=%b err=%0d, got data=%h kind=%0d idx=%0d ",
							"vtx=%0d se=%b be=%b err=%0d"},
							want_res.data, want_res.word_kind, want_res.element_index,
							want_res.strip_vertices, want_res.strip_end, want_res.block_end,
							want_res.error_code, got_res.data, got_res.word_kind,
							got_res.element_index, got_res.strip_vertices, got_res.strip_end,
							got_res.block_end, got_res.error_code);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("strip_packet_parser_core test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		word = '0;
		block_start = 1'b0;
		out_stall = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_faults();
		test_random_blocks(50, 0, 0);
		test_random_blocks(50, 73, 0);
		test_random_blocks(50, 0, 73);
		test_random_blocks(50, 13, 13);
		test_backpressure();
		test_large_strip();

		idle_pct = 0;
		stall_pct = 0;
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("strip_packet_parser_core test passed");
		else
			$display("strip_packet_parser_core test failed");
		$finish;
	end

endmodule
